FILE: rtl/moving_average_filter_assert.svh
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/maf_pkg.sv
`timescale 1ns / 1ps

package maf_pkg;

    localparam int unsigned MAF_MAX_WINDOW = 32;
    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned CFG_W          = 6;
    localparam logic [CFG_W-1:0] CFG_WINDOW_RESET = 6'd10;

endpackage

FILE: rtl/moving_average_filter.sv
`timescale 1ns / 1ps

// Moving average over the last window_len samples held in a ring store. Each
// transfer writes the sample into the ring, then a sequencer reads slots
// 0 .. n-1 one per cycle through a single adder and divides the sum by n in a
// single restoring divider that yields one quotient bit per cycle (n is
// window_len clamped to 1 .. MAX_WINDOW; quotient truncated toward zero).
// The quotient has SUM_W = 16 + clog2(MAX_WINDOW) bits. The result waits in an
// output register; while a stalled output keeps that register full, the
// sequencer holds in S_DONE and o_ready stays low, so a stalled output does
// hold up the next input.
// The ring reads as zero after reset through per-slot valid bits, so no
// clearing pass is needed. window_len is written through i_cfg_we; the user
// must write it only while idle, as the block itself does not enforce this.

module moving_average_filter
    import maf_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = MAF_MAX_WINDOW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_average_out
);

    localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int unsigned BIT_W = $clog2(SUM_W);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SUM   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_ABS   = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]           r_window_len;
    logic [IDX_W-1:0]           r_wp;
    logic [IDX_W-1:0]           r_cnt;
    logic [BIT_W-1:0]           r_bit;
    logic signed [SAMPLE_W-1:0] r_ring [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]      r_ring_vld;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    logic                       r_pend;
    logic signed [SUM_W-1:0]    r_acc;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_average;

    logic [CMP_W-1:0]    cfg_ext;
    logic [CNT_W-1:0]    win_n;
    logic [CNT_W-1:0]    wp_inc;
    logic [IDX_W-1:0]    wp_next;
    logic                in_xfer;
    logic                out_free;
    logic [CNT_W:0]      rem_sh;
    logic                q_bit;
    logic [CNT_W-1:0]    rem_next;
    logic [SUM_W-1:0]    res_full;
    logic signed [SUM_W-1:0] addend;

    // effective window
    always_comb begin
        cfg_ext = CMP_W'(r_window_len);
        if (cfg_ext == '0) begin
            win_n = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
            win_n = CNT_W'(MAX_WINDOW);
        end else begin
            win_n = CNT_W'(cfg_ext);
        end
    end

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    assign wp_inc  = CNT_W'(r_wp) + CNT_W'(1);
    assign wp_next = (wp_inc >= win_n) ? '0 : wp_inc[IDX_W-1:0];

    assign addend = r_rd_vld ? SUM_W'(r_rd_data) : '0;

    // one restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, win_n});
        if (q_bit) begin
            rem_next = CNT_W'(rem_sh - {1'b0, win_n});
        end else begin
            rem_next = rem_sh[CNT_W-1:0];
        end
        res_full = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_SUM;
            S_SUM:   if (CNT_W'(r_cnt) == win_n - CNT_W'(1)) n_state = S_DRAIN;
            S_DRAIN: n_state = S_ABS;
            S_ABS:   n_state = S_DIV;
            S_DIV:   if (r_bit == BIT_W'(SUM_W - 1)) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= CFG_WINDOW_RESET;
            r_wp         <= '0;
            r_ring_vld   <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SUM);
            if (i_cfg_we) begin
                r_window_len <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_wp                <= wp_next;
                r_ring_vld[wp_next] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring store
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ring[wp_next] <= i_sample_in;
        end
        r_rd_data <= r_ring[r_cnt];
        r_rd_vld  <= r_ring_vld[r_cnt];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cnt <= '0;
            r_acc <= '0;
        end else begin
            if (r_state == S_SUM) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (r_pend) begin
                r_acc <= r_acc + addend;
            end
        end
        if (r_state == S_ABS) begin
            r_neg <= r_acc[SUM_W-1];
            r_quo <= r_acc[SUM_W-1] ? (~r_acc + SUM_W'(1)) : r_acc;
            r_rem <= '0;
            r_bit <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= rem_next;
            r_bit <= r_bit + BIT_W'(1);
        end
        if (r_state == S_DONE && out_free) begin
            r_average <= res_full[SAMPLE_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_average_out = r_average;

endmodule

FILE: rtl/maf_checker.sv
`timescale 1ns / 1ps

`include "moving_average_filter_assert.svh"

module maf_checker
    import maf_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [SAMPLE_W-1:0] o_average_out
);

    // busy after every input transfer
    `MAF_ASSERT_NEXT(a_busy_after_in, i_valid && o_ready, !o_ready, "ready after transfer")

    // a result only appears as the sequencer finishes
    `MAF_ASSERT_NOW(a_result_from_busy, $rose(o_valid), $past(!o_ready), "result while idle")

    // no result in the cycle after an input transfer
    `MAF_ASSERT_NEXT(a_no_early_result, i_valid && o_ready, !$rose(o_valid), "result too early")

    // stalled result holds
    `MAF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_average_out),
                     "stalled result changed")

endmodule

bind moving_average_filter maf_checker u_maf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_average_out (o_average_out)
);
